// ===== hdl/sml_pkg.sv =====
// sml_pkg: shared widths, reset values, register indexes and the structs
// that pass between the sweep minimum locator top level, its arm and its lanes.
// No dependencies.
`timescale 1ns / 1ps

package sml_pkg;

	localparam int READ_W  = 10;
	localparam int POS_W   = 8;
	localparam int STEP_W  = 4;
	localparam int MARG_W  = 8;
	localparam int SWEEP_W = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;
	localparam int NUM_LANES  = 2;

	localparam int READING_MAX_DEF   = 1023;
	localparam int TIE_COUNT_MAX_DEF = 255;

	localparam logic [POS_W-1:0]   MIN_ANGLE_RST     = 8'd0;
	localparam logic [POS_W-1:0]   MAX_ANGLE_RST     = 8'd180;
	localparam logic [STEP_W-1:0]  STEP_SIZE_RST     = 4'd1;
	localparam logic [READ_W-1:0]  ALARM_LEVEL_RST   = 10'd800;
	localparam logic [MARG_W-1:0]  TIE_MARGIN_RST    = 8'd10;
	localparam logic [SWEEP_W-1:0] SWEEPS_NEEDED_RST = 3'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_ANGLE     = 3'd0,
		REG_MAX_ANGLE     = 3'd1,
		REG_STEP_SIZE     = 3'd2,
		REG_ALARM_LEVEL   = 3'd3,
		REG_TIE_MARGIN    = 3'd4,
		REG_SWEEPS_NEEDED = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_TICK  = 1'b1
	} cmd_t;

	typedef struct packed {
		logic              start;
		logic              clear;
		logic [READ_W-1:0] reading;
		logic [POS_W-1:0]  arm_pos;
		logic [MARG_W-1:0] margin;
	} lane_ctl_t;

	typedef struct packed {
		logic             busy;
		logic [POS_W-1:0] best_pos;
	} lane_sts_t;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [POS_W-1:0] pos_next;
		logic             rev_next;
	} arm_sts_t;

endpackage

// ===== hdl/sml_in_if.sv =====
// sml_in_if: input request channel (cmd and two readings) with valid/ready.
// Depends on sml_pkg.
`timescale 1ns / 1ps

interface sml_in_if;
	logic                      valid;
	logic                      ready;
	logic                      cmd;
	logic [sml_pkg::READ_W-1:0] reading_a;
	logic [sml_pkg::READ_W-1:0] reading_b;

	modport source (output valid, cmd, reading_a, reading_b, input ready);
	modport sink   (input valid, cmd, reading_a, reading_b, output ready);
endinterface

// ===== hdl/sml_out_if.sv =====
// sml_out_if: result request channel with valid/ready.
// Depends on sml_pkg.
`timescale 1ns / 1ps

interface sml_out_if;
	logic                      valid;
	logic                      ready;
	logic [sml_pkg::POS_W-1:0] arm_position;
	logic                      reversed;
	logic                      search_done;
	logic [sml_pkg::POS_W-1:0] best_pos_a;
	logic [sml_pkg::POS_W-1:0] best_pos_b;
	logic                      alarm;

	modport source (output valid, arm_position, reversed, search_done, best_pos_a,
		best_pos_b, alarm, input ready);
	modport sink   (input valid, arm_position, reversed, search_done, best_pos_a,
		best_pos_b, alarm, output ready);
endinterface

// ===== hdl/sml_arm.sv =====
// sml_arm: arm position and direction registers plus next-step logic.
// Depends on sml_pkg.
`timescale 1ns / 1ps

module sml_arm (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [sml_pkg::POS_W-1:0]  sweep_lo,
	input  logic [sml_pkg::POS_W-1:0]  sweep_hi,
	input  logic [sml_pkg::STEP_W-1:0] step_size,
	input  logic                      advance,
	output sml_pkg::arm_sts_t         sts
);
	import sml_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic             up_q;
	logic signed [POS_W+1:0] pos_s, lo_s, hi_s, cand_s;
	logic             rev;
	logic             up_next;
	logic [POS_W-1:0] pos_next;

	always_comb begin
		pos_s  = $signed({2'b00, pos_q});
		lo_s   = $signed({2'b00, sweep_lo});
		hi_s   = $signed({2'b00, sweep_hi});
		cand_s = up_q ? pos_s + $signed({6'd0, step_size})
		              : pos_s - $signed({6'd0, step_size});
		rev      = (cand_s > hi_s) || (cand_s < lo_s);
		pos_next = cand_s[POS_W-1:0];
		up_next  = up_q;
		if (rev) begin
			if (pos_s > hi_s) begin
				pos_next = sweep_hi;
				up_next  = 1'b0;
			end else if (pos_s < lo_s) begin
				pos_next = sweep_lo;
				up_next  = 1'b1;
			end else begin
				pos_next = pos_q;
				up_next  = !up_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= MIN_ANGLE_RST;
			up_q  <= 1'b1;
		end else if (advance) begin
			pos_q <= pos_next;
			up_q  <= up_next;
		end
	end

	assign sts.pos      = pos_q;
	assign sts.pos_next = pos_next;
	assign sts.rev_next = rev;

endmodule

// ===== hdl/sml_lane.sv =====
// sml_lane: one sensor channel: best reading, best position, tie counter,
// and a multiply then 8-step restoring divider for tie averaging.
// Depends on sml_pkg.
`timescale 1ns / 1ps

module sml_lane #(
	parameter int READING_MAX   = sml_pkg::READING_MAX_DEF,
	parameter int TIE_COUNT_MAX = sml_pkg::TIE_COUNT_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sml_pkg::lane_ctl_t ctl,
	output sml_pkg::lane_sts_t sts
);
	import sml_pkg::*;

	localparam int RW0 = $clog2(READING_MAX + 1);
	localparam int BW  = (RW0 > READ_W) ? RW0 : READ_W;
	localparam int TW  = $clog2(TIE_COUNT_MAX + 1);
	localparam int DW  = $clog2(TIE_COUNT_MAX + 2);
	localparam int PW  = DW + POS_W;
	localparam int QBW = $clog2(POS_W);
	localparam logic [TW-1:0]  TIE_SAT  = TW'(TIE_COUNT_MAX);
	localparam logic [BW-1:0]  BEST_RST = BW'(READING_MAX);
	localparam logic [QBW-1:0] QBIT_TOP = QBW'(POS_W - 1);

	typedef enum logic [2:0] {
		L_IDLE = 3'b001,
		L_MUL  = 3'b010,
		L_DIV  = 3'b100
	} lane_state_t;

	lane_state_t      state_q;
	logic [BW-1:0]    best_rd_q;
	logic [POS_W-1:0] best_pos_q;
	logic [TW-1:0]    tie_q;
	logic [TW-1:0]    mul_t_q;
	logic [POS_W-1:0] arm_q;
	logic [DW-1:0]    div_d_q;
	logic [PW-1:0]    rem_q;
	logic [POS_W-1:0] quo_q;
	logic [QBW-1:0]   qbit_q;

	logic [BW-1:0]    rd_ext, marg_ext, diff;
	logic             higher, replace, tie;
	logic [PW-1:0]    trial;
	logic             fits;
	logic [POS_W-1:0] quo_next;

	always_comb begin
		rd_ext   = BW'(ctl.reading);
		marg_ext = BW'(ctl.margin);
		higher   = best_rd_q > rd_ext;
		diff     = higher ? best_rd_q - rd_ext : rd_ext - best_rd_q;
		replace  = higher && (diff > marg_ext);
		tie      = !replace && (diff <= marg_ext);
		trial    = PW'(div_d_q) << qbit_q;
		fits     = rem_q >= trial;
		quo_next = quo_q;
		quo_next[qbit_q] = fits;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= L_IDLE;
			best_rd_q  <= BEST_RST;
			best_pos_q <= '0;
			tie_q      <= '0;
		end else begin
			case (state_q)
				L_IDLE: begin
					if (ctl.clear) begin
						best_rd_q  <= BEST_RST;
						best_pos_q <= ctl.arm_pos;
						tie_q      <= '0;
					end else if (ctl.start && replace) begin
						best_rd_q  <= rd_ext;
						best_pos_q <= ctl.arm_pos;
						tie_q      <= TW'(1);
					end else if (ctl.start && tie) begin
						if (tie_q != TIE_SAT)
							tie_q <= tie_q + TW'(1);
						state_q <= L_MUL;
					end
				end
				L_MUL: begin
					state_q <= L_DIV;
				end
				L_DIV: begin
					if (qbit_q == '0) begin
						best_pos_q <= quo_next;
						state_q    <= L_IDLE;
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			L_IDLE: begin
				mul_t_q <= tie_q;
				arm_q   <= ctl.arm_pos;
				div_d_q <= DW'(tie_q) + DW'(1);
			end
			L_MUL: begin
				rem_q  <= PW'(best_pos_q) * PW'(mul_t_q) + PW'(arm_q);
				quo_q  <= '0;
				qbit_q <= QBIT_TOP;
			end
			L_DIV: begin
				if (fits)
					rem_q <= rem_q - trial;
				quo_q  <= quo_next;
				qbit_q <= qbit_q - QBW'(1);
			end
			default: ;
		endcase
	end

	assign sts.busy     = (state_q != L_IDLE);
	assign sts.best_pos = best_pos_q;

endmodule

// ===== hdl/sweep_minimum_locator_core.sv =====
// sweep_minimum_locator_core: top level, config registers, search control, result register.
// A tie request first waits for lane averaging (multiply + 8 divide steps) before it commits.
// Requests are taken one at a time: the next waits until the last one commits, and a stalled
// result holds the next request off until the result slot frees.
// Reset (arst_n low, async): registers to defaults, arm at the lower limit moving up, no search.
// Depends on sml_pkg, sml_in_if, sml_out_if, sml_arm, sml_lane.
`timescale 1ns / 1ps

module sweep_minimum_locator_core #(
	parameter int READING_MAX   = sml_pkg::READING_MAX_DEF,
	parameter int TIE_COUNT_MAX = sml_pkg::TIE_COUNT_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sml_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sml_pkg::CFG_DATA_W-1:0] cfg_data,
	sml_in_if.sink                        in_ch,
	sml_out_if.source                     out_ch
);
	import sml_pkg::*;

	// one-hot control: idle waits for a request; wait holds until lanes finish
	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_WAIT = 2'b10
	} top_state_t;

	top_state_t         state_q;
	logic [POS_W-1:0]   sweep_lo_q, sweep_hi_q;
	logic [STEP_W-1:0]  step_size_q;
	logic [READ_W-1:0]  alarm_level_q;
	logic [MARG_W-1:0]  tie_margin_q;
	logic [SWEEP_W-1:0] sweeps_needed_q;

	logic               searching_q;
	logic [SWEEP_W-1:0] rev_count_q;
	logic               alarm_q;
	cmd_t               cmd_q;

	logic               out_valid_q;
	logic [POS_W-1:0]   out_pos_q;
	logic               out_rev_q;
	logic               out_done_q;
	logic [POS_W-1:0]   out_bpa_q;
	logic [POS_W-1:0]   out_bpb_q;
	logic               out_alarm_q;

	logic               in_acc;
	logic               is_tick;
	logic               lanes_busy;
	logic               slot_free;
	logic               commit;
	logic               advance;
	logic [SWEEP_W-1:0] rev_count_inc;
	logic               finish;

	lane_ctl_t ctl_a, ctl_b;
	lane_sts_t sts_a, sts_b;
	arm_sts_t  arm;

	// ---------------- configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_lo_q      <= MIN_ANGLE_RST;
			sweep_hi_q      <= MAX_ANGLE_RST;
			step_size_q     <= STEP_SIZE_RST;
			alarm_level_q   <= ALARM_LEVEL_RST;
			tie_margin_q    <= TIE_MARGIN_RST;
			sweeps_needed_q <= SWEEPS_NEEDED_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_ANGLE:     sweep_lo_q      <= cfg_data[POS_W-1:0];
				REG_MAX_ANGLE:     sweep_hi_q      <= cfg_data[POS_W-1:0];
				REG_STEP_SIZE:     step_size_q     <= cfg_data[STEP_W-1:0];
				REG_ALARM_LEVEL:   alarm_level_q   <= cfg_data[READ_W-1:0];
				REG_TIE_MARGIN:    tie_margin_q    <= cfg_data[MARG_W-1:0];
				REG_SWEEPS_NEEDED: sweeps_needed_q <= cfg_data[SWEEP_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- request acceptance and lane dispatch
	assign in_ch.ready = (state_q == S_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign is_tick     = (in_ch.cmd == CMD_TICK);

	// lanes see the arm position before this tick's move
	always_comb begin
		ctl_a.start   = in_acc && is_tick && searching_q;
		ctl_a.clear   = in_acc && !is_tick;
		ctl_a.reading = in_ch.reading_a;
		ctl_a.arm_pos = arm.pos;
		ctl_a.margin  = tie_margin_q;
		ctl_b         = ctl_a;
		ctl_b.reading = in_ch.reading_b;
	end

	sml_lane #(
		.READING_MAX  (READING_MAX),
		.TIE_COUNT_MAX(TIE_COUNT_MAX)
	) u_lane_a (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl_a),
		.sts   (sts_a)
	);

	sml_lane #(
		.READING_MAX  (READING_MAX),
		.TIE_COUNT_MAX(TIE_COUNT_MAX)
	) u_lane_b (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl_b),
		.sts   (sts_b)
	);

	// ---------------- merge: commit once both lanes are done and the result slot is free
	assign lanes_busy    = sts_a.busy || sts_b.busy;
	assign slot_free     = !out_valid_q || out_ch.ready;
	assign commit        = (state_q == S_WAIT) && !lanes_busy && slot_free;
	assign advance       = commit && (cmd_q == CMD_TICK);
	assign rev_count_inc = rev_count_q + SWEEP_W'(1);
	assign finish        = advance && searching_q && arm.rev_next &&
	                       (rev_count_inc >= sweeps_needed_q);

	sml_arm u_arm (
		.clk      (clk),
		.arst_n   (arst_n),
		.sweep_lo (sweep_lo_q),
		.sweep_hi (sweep_hi_q),
		.step_size(step_size_q),
		.advance  (advance),
		.sts      (arm)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			searching_q <= 1'b0;
			rev_count_q <= '0;
			alarm_q     <= 1'b0;
			cmd_q       <= CMD_START;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						cmd_q   <= cmd_t'(in_ch.cmd);
						state_q <= S_WAIT;
						if (!is_tick) begin
							// start: reopen the search, even if one is running
							searching_q <= 1'b1;
							rev_count_q <= '0;
							alarm_q     <= 1'b0;
						end else if (searching_q &&
							((in_ch.reading_a < alarm_level_q) ||
							 (in_ch.reading_b < alarm_level_q))) begin
							alarm_q <= 1'b1;
						end
					end
				end
				S_WAIT: begin
					if (commit) begin
						state_q <= S_IDLE;
						if (advance && searching_q && arm.rev_next) begin
							rev_count_q <= rev_count_inc;
							if (finish)
								searching_q <= 1'b0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_pos_q   <= advance ? arm.pos_next : arm.pos;
			out_rev_q   <= advance && arm.rev_next;
			out_done_q  <= finish;
			out_bpa_q   <= sts_a.best_pos;
			out_bpb_q   <= sts_b.best_pos;
			out_alarm_q <= alarm_q;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.arm_position = out_pos_q;
	assign out_ch.reversed     = out_rev_q;
	assign out_ch.search_done  = out_done_q;
	assign out_ch.best_pos_a   = out_bpa_q;
	assign out_ch.best_pos_b   = out_bpb_q;
	assign out_ch.alarm        = out_alarm_q;

	// ---------------- assertions
	// no new request is taken while a lane is still averaging
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && lanes_busy))
		else $error("request accepted while a lane is busy");

	// a finished search is always reported on a reversal tick
	a_done_on_rev: assert property (@(posedge clk) disable iff (!arst_n)
		commit && finish |=> out_ch.valid && out_ch.search_done && out_ch.reversed)
		else $error("search_done without reversal");

	// a start request never moves the arm
	a_start_holds_arm: assert property (@(posedge clk) disable iff (!arst_n)
		commit && (cmd_q == CMD_START) |=> out_ch.arm_position == $past(arm.pos)
		&& !out_ch.reversed && !out_ch.search_done)
		else $error("start request moved the arm");

endmodule
